### hdl/ppsch_pkg.sv
package ppsch_pkg;

    // Table geometry
    localparam int MAX_TASKS = 16;
    localparam int ADDR_W    = $clog2(MAX_TASKS);
    localparam int LIM_W     = $clog2(MAX_TASKS + 1);

    // Field widths
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 4;
    localparam int TIME_W  = 16;
    localparam int BURST_W = 12;
    localparam int PRIO_W  = 8;
    localparam int CNT_W   = 5;

    localparam logic [TIME_W-1:0] NOW_MAX   = '1;
    localparam logic [CNT_W-1:0]  COUNT_MAX = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // One slot of the task table
    typedef struct packed {
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] left;
        logic               started;
        logic [TIME_W-1:0]  response;
    } t_entry;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [SLOT_W-1:0]  slot;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_in_item;

    typedef struct packed {
        logic               ran;
        logic [SLOT_W-1:0]  ran_slot;
        logic               finished;
        logic [TIME_W-1:0]  completion;
        logic [TIME_W-1:0]  turnaround;
        logic [TIME_W-1:0]  waiting;
        logic [TIME_W-1:0]  response;
        logic               all_done;
    } t_out_item;

    // Access request from the sequencer to the slot memory
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_ram_req;

endpackage

### hdl/ppsch_ifs.sv
// Input transaction channel
interface ppsch_in_if import ppsch_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result transaction channel
interface ppsch_out_if import ppsch_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/ppsch_slot_ram.sv
module ppsch_slot_ram import ppsch_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_ram_req i_req,
    output t_entry   o_rd_data
);

    t_entry            mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_vld;
    t_entry            r_rd;
    logic              r_rd_vld;

    // Storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd <= mem[i_req.rd_addr];
        end
    end

    // Per-slot written flags; unwritten slots read as no work, not started
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    always_comb begin
        o_rd_data = r_rd;
        if (!r_rd_vld) begin
            o_rd_data.left    = '0;
            o_rd_data.started = 1'b0;
        end
    end

endmodule

### hdl/ppsch_seq.sv
module ppsch_seq import ppsch_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_task_count,
    input  logic             i_start,
    input  t_in_item         i_item,
    output logic             o_idle,
    output t_ram_req         o_ram_req,
    input  t_entry           i_rd_data,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_out_item        o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_TURN = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]        r_state;
    logic [TIME_W-1:0] r_now;
    logic [CNT_W-1:0]  r_done;
    logic [LIM_W-1:0]  r_idx;
    logic              r_pend;
    logic [ADDR_W-1:0] r_pend_addr;
    logic              r_found;
    logic [ADDR_W-1:0] r_best_addr;
    t_entry            r_best;
    logic              r_ran;
    logic              r_fin;
    logic [TIME_W-1:0] r_resp;
    logic [TIME_W-1:0] r_turn;
    logic [TIME_W-1:0] r_wait;

    logic [LIM_W-1:0]   w_limit;
    logic               w_rd_en;
    logic               w_load;
    logic               w_take;
    logic [BURST_W-1:0] w_left_dec;
    logic [TIME_W-1:0]  w_resp;
    logic [TIME_W-1:0]  w_now_inc;
    t_entry             w_load_data;
    t_entry             w_upd_data;

    // Scan range clamps to the table size
    assign w_limit = (int'(i_task_count) > MAX_TASKS) ? LIM_W'(MAX_TASKS)
                                                       : LIM_W'(i_task_count);

    assign w_rd_en = (r_state == S_SCAN) && (r_idx < w_limit);
    assign w_load  = i_start && (i_item.operation == OP_LOAD)
                     && (int'(i_item.slot) < MAX_TASKS);

    // Candidate compare on returning read data
    assign w_take = r_pend && (i_rd_data.arrival <= r_now) && (i_rd_data.left != '0)
                    && (!r_found || (i_rd_data.prio < r_best.prio));

    // Write-back values for the chosen slot
    assign w_left_dec = r_best.left - BURST_W'(1);
    assign w_resp     = r_best.started ? r_best.response : (r_now - r_best.arrival);
    assign w_now_inc  = (r_now == NOW_MAX) ? r_now : (r_now + TIME_W'(1));

    always_comb begin
        w_load_data          = '0;
        w_load_data.arrival  = i_item.arrival;
        w_load_data.burst    = i_item.burst;
        w_load_data.prio     = i_item.prio;
        w_load_data.left     = i_item.burst;
        w_load_data.started  = 1'b0;

        w_upd_data           = r_best;
        w_upd_data.left      = w_left_dec;
        w_upd_data.started   = 1'b1;
        w_upd_data.response  = w_resp;
    end

    // Memory request
    always_comb begin
        o_ram_req         = '0;
        o_ram_req.rd_en   = w_rd_en;
        o_ram_req.rd_addr = r_idx[ADDR_W-1:0];
        if (r_state == S_UPD && r_found) begin
            o_ram_req.wr_en   = 1'b1;
            o_ram_req.wr_addr = r_best_addr;
            o_ram_req.wr_data = w_upd_data;
        end else if (r_state == S_IDLE && w_load) begin
            o_ram_req.wr_en   = 1'b1;
            o_ram_req.wr_addr = ADDR_W'(i_item.slot);
            o_ram_req.wr_data = w_load_data;
        end
    end

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_now   <= '0;
            r_done  <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_pend <= w_rd_en;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_item.operation == OP_CLEAR) begin
                            r_now  <= '0;
                            r_done <= '0;
                        end else if (i_item.operation == OP_TICK) begin
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_rd_en) begin
                        r_idx <= r_idx + LIM_W'(1);
                    end
                    if (w_take) begin
                        r_found <= 1'b1;
                    end
                    if (!w_rd_en && !r_pend) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_now <= w_now_inc;
                    if (r_found && (w_left_dec == '0)) begin
                        if (r_done != COUNT_MAX) begin
                            r_done <= r_done + CNT_W'(1);
                        end
                        r_state <= S_TURN;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_TURN: r_state <= S_WAIT;
                S_WAIT: r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_pend_addr <= r_idx[ADDR_W-1:0];
            if (w_take) begin
                r_best      <= i_rd_data;
                r_best_addr <= r_pend_addr;
            end
        end
        if (r_state == S_UPD) begin
            r_ran  <= r_found;
            r_fin  <= r_found && (w_left_dec == '0);
            r_resp <= w_resp;
        end
        if (r_state == S_TURN) begin
            r_turn <= (r_now >= r_best.arrival) ? (r_now - r_best.arrival) : '0;
        end
        if (r_state == S_WAIT) begin
            r_wait <= (r_turn >= TIME_W'(r_best.burst)) ? (r_turn - TIME_W'(r_best.burst))
                                                        : '0;
        end
    end

    // Result fields
    always_comb begin
        o_res            = '0;
        o_res.ran        = r_ran;
        o_res.ran_slot   = r_ran ? SLOT_W'(r_best_addr) : '0;
        o_res.finished   = r_fin;
        o_res.completion = r_fin ? r_now  : '0;
        o_res.turnaround = r_fin ? r_turn : '0;
        o_res.waiting    = r_fin ? r_wait : '0;
        o_res.response   = r_fin ? r_resp : '0;
        o_res.all_done   = (r_done >= i_task_count);
    end

    assign o_res_valid = (r_state == S_EMIT);
    assign o_idle      = (r_state == S_IDLE);

endmodule

### hdl/preemptive_priority_scheduler.sv
// Load and clear transactions are handled while the sequencer stays idle.
// A tick scans the slots, writes back the chosen slot, computes turnaround
// and waiting when the chosen task finishes, and then emits its result; the slot
// scan reads one memory entry per cycle. One transaction is in work at a time;
// a result may wait in the output register while the next transaction is taken.
// Synchronous active-low reset clears time, finish count and slot valid flags;
// task_count resets to 1.
module preemptive_priority_scheduler import ppsch_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    ppsch_in_if.sink         i_in,
    ppsch_out_if.source      o_out
);

    logic [CNT_W-1:0] r_task_count;
    logic             r_out_valid;
    t_out_item        r_out;

    logic      w_idle;
    logic      w_start;
    t_ram_req  w_ram_req;
    t_entry    w_rd_data;
    logic      w_res_valid;
    logic      w_res_ready;
    t_out_item w_res;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            r_task_count <= i_cfg_wdata;
        end
    end

    assign i_in.ready = w_idle;
    assign w_start    = i_in.valid && w_idle;

    ppsch_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_ram_req),
        .o_rd_data (w_rd_data)
    );

    ppsch_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_count (r_task_count),
        .i_start      (w_start),
        .i_item       (i_in.data),
        .o_idle       (w_idle),
        .o_ram_req    (w_ram_req),
        .i_rd_data    (w_rd_data),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    // Output register
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

### sim/preemptive_priority_scheduler_checker.sv
// Scheduler checker: mirrors the slot table, predicts every tick result and
// compares it with what comes out of the result channel.
module preemptive_priority_scheduler_checker import ppsch_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    ppsch_in_if              i_in,
    ppsch_out_if             i_res,
    output int               o_pending,
    output int               o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirror of the block state
    logic [CNT_W-1:0]   task_count;
    logic [TIME_W-1:0]  now_t;
    logic [CNT_W-1:0]   done_cnt;
    logic [TIME_W-1:0]  arrival_tbl  [MAX_TASKS];
    logic [BURST_W-1:0] burst_tbl    [MAX_TASKS];
    logic [PRIO_W-1:0]  prio_tbl     [MAX_TASKS];
    logic [BURST_W-1:0] left_tbl     [MAX_TASKS];
    logic               started_tbl  [MAX_TASKS];
    logic [TIME_W-1:0]  response_tbl [MAX_TASKS];

    t_out_item expected_results[$];
    int        mismatches = 0;

    task automatic clear_mirror();
        task_count = CNT_W'(1);
        now_t      = '0;
        done_cnt   = '0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            arrival_tbl[i]  = '0;
            burst_tbl[i]    = '0;
            prio_tbl[i]     = '0;
            left_tbl[i]     = '0;
            started_tbl[i]  = 1'b0;
            response_tbl[i] = '0;
        end
        expected_results.delete();
    endtask

    function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] t);
        return (t == NOW_MAX) ? t : t + 1'b1;
    endfunction

    // Apply one accepted transaction to the mirror; ticks queue a result
    task automatic schedule_item(input t_in_item item);
        int                scan_limit;
        int                best;
        logic              found;
        logic [PRIO_W-1:0] best_prio;
        t_out_item         res;
        int                turn;
        int                waited;
        scan_limit = 0;
        best       = 0;
        found      = 1'b0;
        best_prio  = '0;
        res        = '0;
        turn       = 0;
        waited     = 0;
        case (item.operation)
            OP_LOAD: begin
                arrival_tbl[item.slot] = item.arrival;
                burst_tbl[item.slot]   = item.burst;
                prio_tbl[item.slot]    = item.prio;
                left_tbl[item.slot]    = item.burst;
                started_tbl[item.slot] = 1'b0;
            end
            OP_CLEAR: begin
                now_t    = '0;
                done_cnt = '0;
            end
            OP_TICK: begin
                scan_limit = (task_count > MAX_TASKS) ? MAX_TASKS : int'(task_count);
                // lowest priority value among arrived slots with work left
                for (int i = 0; i < scan_limit; i++) begin
                    if (left_tbl[i] != 0 && arrival_tbl[i] <= now_t) begin
                        if (!found || prio_tbl[i] < best_prio) begin
                            found     = 1'b1;
                            best      = i;
                            best_prio = prio_tbl[i];
                        end
                    end
                end
                if (found) begin
                    res.ran      = 1'b1;
                    res.ran_slot = SLOT_W'(best);
                    if (!started_tbl[best]) begin
                        started_tbl[best]  = 1'b1;
                        response_tbl[best] = now_t - arrival_tbl[best];
                    end
                    left_tbl[best] = left_tbl[best] - 1'b1;
                end
                now_t = next_time(now_t);
                if (found && left_tbl[best] == 0) begin
                    if (now_t >= arrival_tbl[best])
                        turn = int'(now_t) - int'(arrival_tbl[best]);
                    if (turn >= int'(burst_tbl[best]))
                        waited = turn - int'(burst_tbl[best]);
                    if (done_cnt != COUNT_MAX)
                        done_cnt = done_cnt + 1'b1;
                    res.finished   = 1'b1;
                    res.completion = now_t;
                    res.turnaround = TIME_W'(turn);
                    res.waiting    = TIME_W'(waited);
                    res.response   = response_tbl[best];
                end
                res.all_done = (done_cnt >= task_count);
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want_v,
                               input logic [TIME_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $display("%0t ns: unexpected result transaction, expected none, actual %h",
                     $time, got);
            mismatches++;
        end else begin
            want = expected_results.pop_front();
            check_field("ran",        TIME_W'(want.ran),      TIME_W'(got.ran));
            check_field("ran_slot",   TIME_W'(want.ran_slot), TIME_W'(got.ran_slot));
            check_field("finished",   TIME_W'(want.finished), TIME_W'(got.finished));
            check_field("completion", want.completion,        got.completion);
            check_field("turnaround", want.turnaround,        got.turnaround);
            check_field("waiting",    want.waiting,           got.waiting);
            check_field("response",   want.response,          got.response);
            check_field("all_done",   TIME_W'(want.all_done), TIME_W'(got.all_done));
        end
    endtask

    // Results are checked before the same-edge input is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_mirror();
        end else begin
            if (i_cfg_we)
                task_count = i_cfg_wdata;
            if (i_res.valid && i_res.ready)
                check_result(i_res.data);
            if (i_in.valid && i_in.ready)
                schedule_item(i_in.data);
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

### sim/preemptive_priority_scheduler_tb.sv
module preemptive_priority_scheduler_tb;
    import ppsch_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                HALF_PERIOD  = 5;
    localparam int                RESET_CYCLES = 5;
    localparam int                SETTLE       = 32;
    localparam int                RANDOM_ITEMS = 700;
    localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;
    logic             sink_ready = 1'b0;

    ppsch_in_if  in_ch();
    ppsch_out_if res_ch();

    int pending_results;
    int fail_total;
    int burst_left = 0;
    int counted_items = 0;
    bit src_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    bit sink_hold = 1'b0;
    int sink_phase = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    assign res_ch.ready = sink_ready;

    preemptive_priority_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (res_ch)
    );

    preemptive_priority_scheduler_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .o_pending    (pending_results),
        .o_fail_count (fail_total)
    );

    // Receiver: stall and run stretches of random length
    always @(posedge i_clk) begin
        if (sink_phase == 0) begin
            sink_hold  = sink_stalls && ($urandom_range(0, 2) == 0);
            sink_phase = sink_hold ? $urandom_range(1, 7) : $urandom_range(1, 14);
        end
        sink_ready <= !sink_hold;
        sink_phase--;
    end

    function automatic t_in_item make_item(input logic [OP_W-1:0] op, input int unsigned s,
                                           input int unsigned a, input int unsigned b,
                                           input int unsigned p);
        t_in_item item;
        item.operation = op;
        item.slot      = SLOT_W'(s);
        item.arrival   = TIME_W'(a);
        item.burst     = BURST_W'(b);
        item.prio      = PRIO_W'(p);
        return item;
    endfunction

    // Sender: bursts of back-to-back transactions separated by random gaps when src_gaps is set
    task automatic send_item(input t_in_item item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = src_gaps ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        if (item.operation != OP_UNUSED)
            counted_items++;
    endtask

    function automatic t_in_item tick_item();
        return make_item(OP_TICK, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Wait until every expected result is back and the block has settled
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_task_count(input int unsigned count);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CNT_W'(count);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int tc;
        int n;
        int work;
        int latest;
        int ticks;
        int r;
        int arr;
        int bst;
        int pr;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_rst_n     <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        @(posedge i_clk);

        // Directed: idle tick at reset count, preemption, ties, zero burst
        send_item(tick_item());
        set_task_count(3);
        send_item(make_item(OP_LOAD, 0, 0, 2, 5));
        send_item(make_item(OP_LOAD, 1, 1, 1, 0));
        send_item(make_item(OP_LOAD, 2, 0, 0, 0));
        send_item(make_item(OP_LOAD, 15, 65535, 4095, 255));
        send_item(make_item(OP_UNUSED, 15, 65535, 4095, 255));
        repeat (5) send_item(tick_item());
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD, 0, 0, 1, 7));
        send_item(make_item(OP_LOAD, 1, 0, 1, 7));
        repeat (2) send_item(tick_item());
        send_item(make_item(OP_LOAD, 2, 0, 1, 255));
        send_item(tick_item());
        // empty scan: all_done holds with a count of zero
        set_task_count(0);
        send_item(tick_item());
        // full table scan reaches the last slot
        set_task_count(16);
        send_item(make_item(OP_LOAD, 15, 0, 1, 0));
        send_item(tick_item());

        // Random phases: load a task set, then tick it to completion with noise
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            drain();
            src_gaps    = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       tc = 0;
                1:       tc = 16;
                2:       tc = $urandom_range(17, 31);
                default: tc = $urandom_range(1, 16);
            endcase
            set_task_count(tc);
            send_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
            repeat ($urandom_range(0, 2))
                send_item(make_item(OP_LOAD, $urandom, $urandom, $urandom, $urandom));
            n = (tc == 0) ? 4 : ((tc > MAX_TASKS) ? MAX_TASKS : tc);
            work   = 0;
            latest = 0;
            for (int s = 0; s < n; s++) begin
                arr = $urandom_range(0, 24);
                bst = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
                pr  = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
                send_item(make_item(OP_LOAD, s, arr, bst, pr));
                work += bst;
                if (arr > latest)
                    latest = arr;
            end
            ticks = work + latest + $urandom_range(1, 4);
            for (int k = 0; k < ticks; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    send_item(make_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
                else if (r < 6)
                    send_item(make_item(OP_LOAD, $urandom_range(0, 15), $urandom_range(0, 30),
                                        $urandom_range(0, 4), $urandom));
                else if (r == 6)
                    send_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
                else
                    send_item(tick_item());
            end
        end

        // Finish count saturates: reload one short task over and over
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        set_task_count(31);
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        repeat (34) begin
            send_item(make_item(OP_LOAD, 0, 0, 1, 0));
            send_item(tick_item());
        end

        // Clear mid-run: turnaround below burst gives zero waiting
        set_task_count(1);
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD, 0, 0, 4, 9));
        repeat (3) send_item(tick_item());
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0));
        repeat (2) send_item(tick_item());

        drain();
        if (fail_total == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
